[rtl/core/trg_pkg.sv]
`timescale 1ns / 1ps

package trg_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int POS_WIDTH  = 16;
    localparam int OP_WIDTH   = 4;
    localparam int OV_WIDTH   = 15;
    localparam int DLY_WIDTH  = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [OV_WIDTH-1:0]  RST_OVERSHOOT = '0;
    localparam logic [DLY_WIDTH-1:0] RST_DELAY     = DLY_WIDTH'(600);
    localparam logic signed [POS_WIDTH-1:0] RST_HOME_ALT = POS_WIDTH'(-300);
    localparam logic signed [POS_WIDTH-1:0] RST_HOME_AZ  = POS_WIDTH'(-800);

    typedef enum logic [OP_WIDTH-1:0] {
        OP_NONE     = 4'd0,
        OP_STOP_ALL = 4'd1,
        OP_ALT_NEG  = 4'd2,
        OP_ALT_POS  = 4'd3,
        OP_ALT_STOP = 4'd4,
        OP_AZ_NEG   = 4'd5,
        OP_AZ_POS   = 4'd6,
        OP_AZ_STOP  = 4'd7,
        OP_HOME     = 4'd8,
        OP_GOTO     = 4'd9
    } t_op;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ALT_OVERSHOOT = 3'd0,
        CFG_AZ_OVERSHOOT  = 3'd1,
        CFG_REVERSE_DELAY = 3'd2,
        CFG_HOME_ALT      = 3'd3,
        CFG_HOME_AZ       = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_NEG  = 2'd0,
        REQ_POS  = 2'd1,
        REQ_STOP = 2'd2,
        REQ_GOTO = 2'd3
    } t_request;

    typedef enum logic [1:0] {
        MOT_STOPPED = 2'd0,
        MOT_POS     = 2'd1,
        MOT_NEG     = 2'd2
    } t_motion;

    typedef struct packed {
        logic [OP_WIDTH-1:0]          op;
        logic signed [POS_WIDTH-1:0]  goto_alt;
        logic signed [POS_WIDTH-1:0]  goto_az;
        logic signed [POS_WIDTH-1:0]  alt_position;
        logic signed [POS_WIDTH-1:0]  az_position;
        logic [TIME_WIDTH-1:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic alt_drive_up;
        logic alt_drive_down;
        logic az_drive_pos;
        logic az_drive_neg;
    } t_out_item;

    // per-axis command decoded from one request
    typedef struct packed {
        logic                         update;
        logic                         set_req;
        t_request                     req;
        logic                         set_target;
        logic signed [POS_WIDTH-1:0]  target;
    } t_axis_ctl;

endpackage

[rtl/core/trg_axis.sv]
`timescale 1ns / 1ps

module trg_axis
    import trg_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_axis_ctl                   i_ctl,
    input  logic signed [POS_WIDTH-1:0] i_position,
    input  logic [TIME_WIDTH-1:0]       i_now,
    input  logic [OV_WIDTH-1:0]         i_overshoot,
    input  logic [DLY_WIDTH-1:0]        i_delay,
    output t_motion                     o_motion
);

    localparam int WIDE = POS_WIDTH + 2;

    t_request                     r_req,       n_req;
    t_motion                      r_motion,    n_motion;
    logic [TIME_WIDTH-1:0]        r_stop_time, n_stop_time;
    logic signed [POS_WIDTH-1:0]  r_target,    n_target;

    t_request                     req_cur;
    t_request                     move;
    logic signed [WIDE-1:0]       pos_w;
    logic signed [WIDE-1:0]       tgt_w;
    logic signed [WIDE-1:0]       ov_w;
    logic signed [WIDE-1:0]       band_hi;
    logic signed [WIDE-1:0]       band_lo;
    logic [TIME_WIDTH-1:0]        elapsed;
    logic                         ready;

    always_comb begin
        req_cur  = i_ctl.set_req    ? i_ctl.req    : r_req;
        n_target = i_ctl.set_target ? i_ctl.target : r_target;

        // widen so the dead band never wraps
        pos_w   = WIDE'(i_position);
        tgt_w   = WIDE'(n_target);
        ov_w    = signed'({{(WIDE-OV_WIDTH){1'b0}}, i_overshoot});
        band_hi = tgt_w + ov_w;
        band_lo = tgt_w - ov_w;

        move = req_cur;
        if (req_cur == REQ_GOTO) begin
            if (pos_w > band_hi) begin
                move = REQ_NEG;
            end else if (pos_w < band_lo) begin
                move = REQ_POS;
            end else begin
                move = REQ_STOP;
            end
        end

        elapsed = i_now - r_stop_time;
        ready   = elapsed > {{(TIME_WIDTH-DLY_WIDTH){1'b0}}, i_delay};

        n_req       = req_cur;
        n_motion    = r_motion;
        n_stop_time = r_stop_time;
        unique case (move)
            REQ_NEG: begin
                if (r_motion == MOT_POS) begin
                    n_motion    = MOT_STOPPED;
                    n_stop_time = i_now;
                end else if (r_motion == MOT_STOPPED && ready) begin
                    n_motion = MOT_NEG;
                end
            end
            REQ_POS: begin
                if (r_motion == MOT_NEG) begin
                    n_motion    = MOT_STOPPED;
                    n_stop_time = i_now;
                end else if (r_motion == MOT_STOPPED && ready) begin
                    n_motion = MOT_POS;
                end
            end
            default: begin
                // stop held: re-stamp every request
                n_motion    = MOT_STOPPED;
                n_stop_time = i_now;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= REQ_STOP;
            r_motion    <= MOT_STOPPED;
            r_stop_time <= '0;
            r_target    <= '0;
        end else if (i_ctl.update) begin
            r_req       <= n_req;
            r_motion    <= n_motion;
            r_stop_time <= n_stop_time;
            r_target    <= n_target;
        end
    end

    assign o_motion = n_motion;

endmodule

[rtl/core/two_axis_reversal_guard_core.sv]
`timescale 1ns / 1ps
// An accepted request is held in the input register; its result is registered into
// the result register on o_data once that register is free or draining.
// Throughput: one request per cycle while the receiver does not stall; each axis
// update is a dead-band add, subtract and compare and one time subtraction
// between the input and result registers.
// Reset (synchronous, active low) stops both axes, clears targets and stop
// times, empties both registers and loads the configuration defaults.
module two_axis_reversal_guard_core
    import trg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_item                 i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_item                o_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data
);

    logic [OV_WIDTH-1:0]          r_alt_overshoot;
    logic [OV_WIDTH-1:0]          r_az_overshoot;
    logic [DLY_WIDTH-1:0]         r_delay;
    logic signed [POS_WIDTH-1:0]  r_home_alt;
    logic signed [POS_WIDTH-1:0]  r_home_az;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       accept;
    logic       advance;
    t_axis_ctl  alt_ctl;
    t_axis_ctl  az_ctl;
    t_motion    alt_motion;
    t_motion    az_motion;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_overshoot <= RST_OVERSHOOT;
            r_az_overshoot  <= RST_OVERSHOOT;
            r_delay         <= RST_DELAY;
            r_home_alt      <= RST_HOME_ALT;
            r_home_az       <= RST_HOME_AZ;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ALT_OVERSHOOT: r_alt_overshoot <= i_cfg_data[OV_WIDTH-1:0];
                CFG_AZ_OVERSHOOT:  r_az_overshoot  <= i_cfg_data[OV_WIDTH-1:0];
                CFG_REVERSE_DELAY: r_delay         <= i_cfg_data[DLY_WIDTH-1:0];
                CFG_HOME_ALT:      r_home_alt      <= signed'(i_cfg_data[POS_WIDTH-1:0]);
                CFG_HOME_AZ:       r_home_az       <= signed'(i_cfg_data[POS_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    // advance the held request when the result register is free or draining
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        alt_ctl            = '0;
        az_ctl             = '0;
        alt_ctl.update     = advance;
        az_ctl.update      = advance;
        alt_ctl.req        = REQ_STOP;
        az_ctl.req         = REQ_STOP;
        alt_ctl.target     = r_in.goto_alt;
        az_ctl.target      = r_in.goto_az;
        unique case (t_op'(r_in.op))
            OP_STOP_ALL: begin
                alt_ctl.set_req = 1'b1;
                az_ctl.set_req  = 1'b1;
            end
            OP_ALT_NEG: begin
                alt_ctl.set_req = 1'b1;
                alt_ctl.req     = REQ_NEG;
            end
            OP_ALT_POS: begin
                alt_ctl.set_req = 1'b1;
                alt_ctl.req     = REQ_POS;
            end
            OP_ALT_STOP: alt_ctl.set_req = 1'b1;
            OP_AZ_NEG: begin
                az_ctl.set_req = 1'b1;
                az_ctl.req     = REQ_NEG;
            end
            OP_AZ_POS: begin
                az_ctl.set_req = 1'b1;
                az_ctl.req     = REQ_POS;
            end
            OP_AZ_STOP: az_ctl.set_req = 1'b1;
            OP_HOME: begin
                alt_ctl.set_req    = 1'b1;
                az_ctl.set_req     = 1'b1;
                alt_ctl.req        = REQ_GOTO;
                az_ctl.req         = REQ_GOTO;
                alt_ctl.set_target = 1'b1;
                az_ctl.set_target  = 1'b1;
                alt_ctl.target     = r_home_alt;
                az_ctl.target      = r_home_az;
            end
            OP_GOTO: begin
                alt_ctl.set_req    = 1'b1;
                az_ctl.set_req     = 1'b1;
                alt_ctl.req        = REQ_GOTO;
                az_ctl.req         = REQ_GOTO;
                alt_ctl.set_target = 1'b1;
                az_ctl.set_target  = 1'b1;
            end
            default: ;
        endcase
    end

    trg_axis u_alt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (alt_ctl),
        .i_position  (r_in.alt_position),
        .i_now       (r_in.now_ms),
        .i_overshoot (r_alt_overshoot),
        .i_delay     (r_delay),
        .o_motion    (alt_motion)
    );

    trg_axis u_az (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (az_ctl),
        .i_position  (r_in.az_position),
        .i_now       (r_in.now_ms),
        .i_overshoot (r_az_overshoot),
        .i_delay     (r_delay),
        .o_motion    (az_motion)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_out.alt_drive_up   <= (alt_motion == MOT_POS);
            r_out.alt_drive_down <= (alt_motion == MOT_NEG);
            r_out.az_drive_pos   <= (az_motion == MOT_POS);
            r_out.az_drive_neg   <= (az_motion == MOT_NEG);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[sim/two_axis_reversal_guard_core_tb.sv]
`timescale 1ns / 1ps

module two_axis_reversal_guard_core_tb;
    import trg_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 250;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    t_in_item                 i_data = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    t_out_item                o_data;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_WIDTH-1:0]     i_cfg_data = '0;

    two_axis_reversal_guard_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    typedef struct {
        t_request                    req;
        t_motion                     mot;
        logic [TIME_WIDTH-1:0]       stamp;
        logic signed [POS_WIDTH-1:0] target;
    } t_axis_track;

    // shadow of the configuration registers
    logic [OV_WIDTH-1:0]         band_alt = RST_OVERSHOOT;
    logic [OV_WIDTH-1:0]         band_az = RST_OVERSHOOT;
    logic [DLY_WIDTH-1:0]        restart_delay = RST_DELAY;
    logic signed [POS_WIDTH-1:0] home_alt_tgt = RST_HOME_ALT;
    logic signed [POS_WIDTH-1:0] home_az_tgt = RST_HOME_AZ;

    t_axis_track alt_trk = '{REQ_STOP, MOT_STOPPED, '0, '0};
    t_axis_track az_trk = '{REQ_STOP, MOT_STOPPED, '0, '0};

    t_in_item  request_q[$];
    t_out_item drive_expect[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int accepted = 0;
    int checked = 0;
    int held_edges = 0;
    int settings_used = 1;

    // stimulus walk state
    logic [TIME_WIDTH-1:0] ms = '0;
    int alt_at = 0;
    int az_at = 0;
    int alt_aim = 0;
    int az_aim = 0;

    function automatic t_axis_track advance_axis(t_axis_track a, logic signed [POS_WIDTH-1:0] pos,
                                                 logic [OV_WIDTH-1:0] band,
                                                 logic [TIME_WIDTH-1:0] now);
        t_request              mv;
        int                    hi;
        int                    lo;
        logic [TIME_WIDTH-1:0] elapsed;
        logic                  ready;
        mv = a.req;
        hi = int'(a.target) + int'(band);
        lo = int'(a.target) - int'(band);
        if (mv == REQ_GOTO) begin
            if (int'(pos) > hi)
                mv = REQ_NEG;
            else if (int'(pos) < lo)
                mv = REQ_POS;
            else
                mv = REQ_STOP;
        end
        elapsed = now - a.stamp;
        ready = elapsed > TIME_WIDTH'(restart_delay);
        case (mv)
            REQ_STOP: begin
                a.mot = MOT_STOPPED;
                a.stamp = now;
            end
            REQ_NEG: begin
                if (a.mot == MOT_POS) begin
                    a.mot = MOT_STOPPED;
                    a.stamp = now;
                end else if (a.mot == MOT_STOPPED && ready) begin
                    a.mot = MOT_NEG;
                end
            end
            default: begin
                if (a.mot == MOT_NEG) begin
                    a.mot = MOT_STOPPED;
                    a.stamp = now;
                end else if (a.mot == MOT_STOPPED && ready) begin
                    a.mot = MOT_POS;
                end
            end
        endcase
        return a;
    endfunction

    task automatic predict_drive(t_in_item it);
        t_out_item res;
        case (it.op)
            OP_STOP_ALL: begin
                alt_trk.req = REQ_STOP;
                az_trk.req = REQ_STOP;
            end
            OP_ALT_NEG:  alt_trk.req = REQ_NEG;
            OP_ALT_POS:  alt_trk.req = REQ_POS;
            OP_ALT_STOP: alt_trk.req = REQ_STOP;
            OP_AZ_NEG:   az_trk.req = REQ_NEG;
            OP_AZ_POS:   az_trk.req = REQ_POS;
            OP_AZ_STOP:  az_trk.req = REQ_STOP;
            OP_HOME: begin
                alt_trk.target = home_alt_tgt;
                az_trk.target = home_az_tgt;
                alt_trk.req = REQ_GOTO;
                az_trk.req = REQ_GOTO;
            end
            OP_GOTO: begin
                alt_trk.target = it.goto_alt;
                az_trk.target = it.goto_az;
                alt_trk.req = REQ_GOTO;
                az_trk.req = REQ_GOTO;
            end
            default: ;
        endcase
        alt_trk = advance_axis(alt_trk, it.alt_position, band_alt, it.now_ms);
        az_trk = advance_axis(az_trk, it.az_position, band_az, it.now_ms);
        res.alt_drive_up = (alt_trk.mot == MOT_POS);
        res.alt_drive_down = (alt_trk.mot == MOT_NEG);
        res.az_drive_pos = (az_trk.mot == MOT_POS);
        res.az_drive_neg = (az_trk.mot == MOT_NEG);
        drive_expect.push_back(res);
    endtask

    always @(posedge i_clk) begin : drive_requests
        logic advance;
        if (i_rst_n) begin
            if (i_valid && o_stall)
                held_edges++;
            if (i_valid && !o_stall) begin
                predict_drive(i_data);
                accepted++;
            end
            advance = !i_valid || !o_stall;
            if (advance) begin
                if (request_q.size() != 0 &&
                    !(tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)) begin
                    i_valid <= 1'b1;
                    i_data <= request_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_pin(string pin, logic want, logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b, got %b", $time, pin, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_drives
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (drive_expect.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %b", $time, o_data);
                    mismatches++;
                end else begin
                    want = drive_expect.pop_front();
                    check_pin("alt_drive_up", want.alt_drive_up, o_data.alt_drive_up);
                    check_pin("alt_drive_down", want.alt_drive_down, o_data.alt_drive_down);
                    check_pin("az_drive_pos", want.az_drive_pos, o_data.az_drive_pos);
                    check_pin("az_drive_neg", want.az_drive_neg, o_data.az_drive_neg);
                    checked++;
                end
            end
            i_stall <= (hold_left != 0) ||
                       (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
        end
    end

    // long receiver hold-off, started from the sequence below
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("two_axis_reversal_guard_core verification failed");
            $finish;
        end
    end

    function automatic int clamp_pos(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic add_request(logic [OP_WIDTH-1:0] op, int g_alt, int g_az, int p_alt,
                               int p_az, logic [TIME_WIDTH-1:0] now);
        t_in_item it;
        it.op = op;
        it.goto_alt = POS_WIDTH'(g_alt);
        it.goto_az = POS_WIDTH'(g_az);
        it.alt_position = POS_WIDTH'(p_alt);
        it.az_position = POS_WIDTH'(p_az);
        it.now_ms = now;
        request_q.push_back(it);
    endtask

    task automatic set_idle(int mode);
        tx_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 29 : 0;
        rx_idle_pct = (mode == 2) ? 57 : (mode == 3) ? 29 : 0;
    endtask

    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || i_valid || drive_expect.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_WIDTH-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ALT_OVERSHOOT: band_alt = val[OV_WIDTH-1:0];
            CFG_AZ_OVERSHOOT:  band_az = val[OV_WIDTH-1:0];
            CFG_REVERSE_DELAY: restart_delay = val;
            CFG_HOME_ALT:      home_alt_tgt = val;
            CFG_HOME_AZ:       home_az_tgt = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_WIDTH-1:0] ov_alt, logic [CFG_WIDTH-1:0] ov_az,
                              logic [CFG_WIDTH-1:0] dly, logic [CFG_WIDTH-1:0] h_alt,
                              logic [CFG_WIDTH-1:0] h_az);
        write_cfg(CFG_ALT_OVERSHOOT, ov_alt);
        write_cfg(CFG_AZ_OVERSHOOT, ov_az);
        write_cfg(CFG_REVERSE_DELAY, dly);
        write_cfg(CFG_HOME_ALT, h_alt);
        write_cfg(CFG_HOME_AZ, h_az);
        settings_used++;
    endtask

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic queue_random(int count);
        t_in_item it;
        int       pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 20)
                it.op = OP_GOTO;
            else if (pick < 25)
                it.op = OP_HOME;
            else if (pick < 60)
                it.op = OP_WIDTH'($urandom_range(int'(OP_AZ_STOP), int'(OP_ALT_NEG)));
            else if (pick < 67)
                it.op = OP_STOP_ALL;
            else if (pick < 71)
                it.op = OP_WIDTH'(int'(OP_GOTO) + $urandom_range(6, 1));
            else
                it.op = OP_NONE;

            // targets mostly near the current position, now and then anywhere
            if ($urandom_range(9) == 0) begin
                it.goto_alt = POS_WIDTH'($urandom);
                it.goto_az = POS_WIDTH'($urandom);
            end else begin
                it.goto_alt = POS_WIDTH'(clamp_pos(alt_at + jitter(int'(band_alt) + 300)));
                it.goto_az = POS_WIDTH'(clamp_pos(az_at + jitter(int'(band_az) + 300)));
            end
            if (it.op == OP_GOTO) begin
                alt_aim = int'(it.goto_alt);
                az_aim = int'(it.goto_az);
            end else if (it.op == OP_HOME) begin
                alt_aim = int'(home_alt_tgt);
                az_aim = int'(home_az_tgt);
            end

            // walk the axes toward the aim so the dead band gets reached
            pick = $urandom_range(99);
            if (pick < 5) begin
                alt_at = int'($signed(POS_WIDTH'($urandom)));
                az_at = int'($signed(POS_WIDTH'($urandom)));
            end else if (pick < 50) begin
                alt_at = clamp_pos(alt_at + (alt_aim - alt_at) / 2 + jitter(4));
                az_at = clamp_pos(az_at + (az_aim - az_at) / 2 + jitter(4));
            end else begin
                alt_at = clamp_pos(alt_at + jitter(int'(band_alt) + 40));
                az_at = clamp_pos(az_at + jitter(int'(band_az) + 40));
            end
            it.alt_position = POS_WIDTH'(alt_at);
            it.az_position = POS_WIDTH'(az_at);

            pick = $urandom_range(99);
            if (pick < 55)
                ms = ms + $urandom_range(int'(restart_delay) / 4 + 1);
            else if (pick < 85)
                ms = ms + TIME_WIDTH'(restart_delay) + $urandom_range(2) - 1;
            else if (pick < 95)
                ms = ms + $urandom_range(2 * int'(restart_delay) + 5);
            else
                ms = $urandom;
            it.now_ms = ms;
            request_q.push_back(it);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reversal timing at the delay boundary, every op, extremes, wrap
        set_idle(0);
        add_request(OP_NONE, 0, 0, -32768, 32767, 32'd0);
        add_request(OP_ALT_POS, 0, 0, 0, -1, 32'd600);
        add_request(OP_NONE, 0, 0, 0, 0, 32'd601);
        add_request(OP_ALT_NEG, 0, 0, 0, 0, 32'd700);
        add_request(OP_NONE, 0, 0, 0, 0, 32'd1301);
        add_request(OP_AZ_NEG, 0, 0, 0, 0, 32'd1400);
        add_request(OP_AZ_POS, 0, 0, 0, 0, 32'd2000);
        add_request(OP_AZ_NEG, 0, 0, 0, 0, 32'd2100);
        add_request(OP_AZ_STOP, 0, 0, 0, 0, 32'd2800);
        add_request(OP_ALT_STOP, 0, 0, 0, 0, 32'd2801);
        add_request(OP_AZ_POS, 0, 0, 0, 0, 32'd3500);
        add_request(OP_STOP_ALL, 0, 0, 0, 0, 32'd3501);
        for (int k = 1; k <= 6; k++)
            add_request(OP_WIDTH'(int'(OP_GOTO) + k), 32767, -32768, -1, 0, 32'd4000 + k);
        // time wrap: stamp just below the top, start just past the delay
        add_request(OP_STOP_ALL, 0, 0, 0, 0, 32'hFFFF_FF00);
        add_request(OP_ALT_POS, 0, 0, 0, 0, 32'h0000_0159);
        add_request(OP_HOME, 0, 0, 32767, -32768, 32'h0010_0000);
        add_request(OP_GOTO, -32768, 32767, 32767, -32768, 32'h8000_0000);
        add_request(OP_GOTO, 32767, -32768, 32767, -32768, 32'hFFFF_FFFF);
        add_request(OP_GOTO, 12345, -4321, 32767, -32768, 32'h4000_0000);
        wait_quiet();

        queue_random(RANDOM_PER_PHASE);
        wait_quiet();

        set_config(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF);
        set_idle(1);
        queue_random(RANDOM_PER_PHASE);
        wait_quiet();

        set_config(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000);
        set_idle(2);
        queue_random(RANDOM_PER_PHASE);
        wait_quiet();

        // hold the receiver off while requests keep coming so the block backs up
        set_config(16'($urandom_range(200)), 16'($urandom_range(200)),
                   16'($urandom_range(100, 1)), 16'($urandom), 16'($urandom));
        set_idle(3);
        @(posedge i_clk);
        hold_left <= HOLD_CYCLES;
        queue_random(RANDOM_PER_PHASE);
        wait_quiet();

        set_config(16'd5, 16'd300, 16'd600, 16'($signed(-300)), 16'($signed(-800)));
        set_idle(0);
        ms = 32'hFFFF_0000 + $urandom_range(60000);
        queue_random(RANDOM_PER_PHASE);
        wait_quiet();

        for (int mode = 1; mode <= 3; mode++) begin
            set_config(16'($urandom_range(400)), 16'($urandom_range(400)),
                       16'($urandom_range(2000)), 16'($urandom), 16'($urandom));
            set_idle(mode);
            queue_random(RANDOM_PER_PHASE);
            wait_quiet();
        end

        $display("ran %0d requests over %0d register settings, checked %0d drive results",
                 accepted, settings_used, checked);
        $display("input held off on %0d edges, %0d mismatches", held_edges, mismatches);
        if (mismatches == 0)
            $display("two_axis_reversal_guard_core verification clean");
        else
            $display("two_axis_reversal_guard_core verification failed");
        $finish;
    end

endmodule

[two_axis_reversal_guard_core.f]
rtl/core/trg_pkg.sv
rtl/core/trg_axis.sv
rtl/core/two_axis_reversal_guard_core.sv
sim/two_axis_reversal_guard_core_tb.sv
